// ===== hdl/etsr_pkg.sv =====
package etsr_pkg;

   // Field widths fixed by the transaction formats
   localparam int unsigned FRAME_BITS     = 8;
   localparam int unsigned DURATION_WIDTH = 20;
   localparam int unsigned PERIOD_W       = 16;
   localparam int unsigned TIMEOUT_W      = 20;
   localparam int unsigned VALUE_W        = 7;
   localparam int unsigned COUNT_W        = 32;

   // Divider sizing: effective duration, numerator 2*d + p, divisor 2*p
   localparam int unsigned DUR_W = (DURATION_WIDTH > TIMEOUT_W) ? DURATION_WIDTH : TIMEOUT_W;
   localparam int unsigned NUM_W = DUR_W + 2;
   localparam int unsigned DIV_W = PERIOD_W + 1;
   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   // Largest bit count kept exactly; bigger counts only ever mean overrun
   localparam int unsigned NSAT_W = 4;
   localparam int unsigned TOT_W  = NSAT_W + 1;
   localparam int unsigned BITS_W = $clog2(FRAME_BITS);

   // Configuration port
   localparam int unsigned CSR_DATA_W  = TIMEOUT_W;
   localparam int unsigned CSR_INDEX_W = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BIT_PERIOD = 1'b0,
      CSR_TIMEOUT    = 1'b1
   } csr_index_type;

   localparam logic [PERIOD_W-1:0]  BIT_PERIOD_RESET = 16'd3333;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET    = 20'd50000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_APPLY
   } state_type;

   typedef struct packed {
      logic                      run_level;
      logic [DURATION_WIDTH-1:0] run_ticks;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               sequence_error;
      logic [COUNT_W-1:0] error_count;
      logic [COUNT_W-1:0] frame_count;
   } rsp_type;

endpackage

// ===== hdl/edge_timed_serial_receiver_core.sv =====
// Edge-timed serial receiver for 8N1 frames, least significant bit first. Each request
// transaction carries one line run (level and duration in ticks). While idle, high runs
// are taken and dropped without a stall, and a low run opens a frame. Every run inside a frame is
// converted to a rounded count of bit periods, floor((2*d + p) / (2*p)), by one shared
// restoring divider that resolves one quotient bit per cycle. A run inside a frame, or a
// frame-opening low run, is accepted, divided and then applied, and the request side is
// stalled meanwhile, also through any wait in the apply step. A run of at least
// timeout_ticks counts as timeout_ticks and closes the frame. A frame that lands on
// exactly eight bits (nine ending low is taken as eight) yields one response transaction:
// frame bits one to seven as value, a sequence check against the previous value plus one
// modulo 128, and wrapping error and frame counters. Any other closed frame is dropped
// silently. The response sits in an output register, so the next run is accepted while
// it waits; only a second completed frame waits for the register to drain. Write the
// configuration registers only while the block is idle.
module edge_timed_serial_receiver_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  etsr_pkg::req_type                       req_payload,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output etsr_pkg::rsp_type                       rsp_payload,
   input  logic                                    csr_we,
   input  logic [etsr_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [etsr_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   // Configuration
   logic [etsr_pkg::PERIOD_W-1:0]   period_ff;
   logic [etsr_pkg::TIMEOUT_W-1:0]  timeout_ff;

   // Sequencer and frame state
   etsr_pkg::state_type             state_ff, state_in;
   logic                            in_frame_ff, in_frame_in;
   logic                            first_run_ff, first_run_in;
   logic [etsr_pkg::BITS_W-1:0]     bit_count_ff, bit_count_in;
   logic [etsr_pkg::FRAME_BITS-1:0] frame_bits_ff, frame_bits_in;
   logic [etsr_pkg::VALUE_W-1:0]    prev_ff, prev_in;
   logic [etsr_pkg::COUNT_W-1:0]    errors_ff, errors_in;
   logic [etsr_pkg::COUNT_W-1:0]    frames_ff, frames_in;

   // Run held for the duration of the division
   logic                            level_ff, level_in;
   logic                            timed_out_ff, timed_out_in;

   // Shared divider
   logic [etsr_pkg::NUM_W-1:0]      quo_ff, quo_in;
   logic [etsr_pkg::DIV_W-1:0]      rem_ff, rem_in;
   logic [etsr_pkg::DIV_W-1:0]      div_ff, div_in;
   logic [etsr_pkg::CNT_W-1:0]      cnt_ff, cnt_in;

   // Output register
   logic                            rsp_valid_ff, rsp_valid_in;
   etsr_pkg::rsp_type               rsp_ff, rsp_in;

   // Combinational helpers
   logic                            req_take;
   logic                            load_rsp;
   logic [etsr_pkg::DUR_W-1:0]      ticks_ext;
   logic [etsr_pkg::DUR_W-1:0]      tmo_ext;
   logic                            run_timeout;
   logic [etsr_pkg::DUR_W-1:0]      dur;
   logic [etsr_pkg::PERIOD_W-1:0]   period_eff;
   logic [etsr_pkg::DIV_W:0]        shifted;
   logic [etsr_pkg::DIV_W+1:0]      trial;
   logic [etsr_pkg::NUM_W-1:0]      n_eff;
   logic [etsr_pkg::NSAT_W-1:0]     n_sat;
   logic [etsr_pkg::TOT_W-1:0]      total_raw;
   logic [etsr_pkg::TOT_W-1:0]      total;
   logic [etsr_pkg::FRAME_BITS-1:0] bits_new;
   logic                            frame_done;
   logic                            emit;
   logic [etsr_pkg::VALUE_W-1:0]    value_new;
   logic                            serr;

   assign req_stall   = (state_ff != etsr_pkg::ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= etsr_pkg::BIT_PERIOD_RESET;
         timeout_ff <= etsr_pkg::TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            etsr_pkg::CSR_BIT_PERIOD: period_ff  <= csr_wdata[etsr_pkg::PERIOD_W-1:0];
            etsr_pkg::CSR_TIMEOUT:    timeout_ff <= csr_wdata[etsr_pkg::TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= etsr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Frame state, counters and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         first_run_ff  <= 1'b1;
         bit_count_ff  <= '0;
         frame_bits_ff <= '0;
         prev_ff       <= '0;
         errors_ff     <= '0;
         frames_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_frame_ff   <= in_frame_in;
         first_run_ff  <= first_run_in;
         bit_count_ff  <= bit_count_in;
         frame_bits_ff <= frame_bits_in;
         prev_ff       <= prev_in;
         errors_ff     <= errors_in;
         frames_ff     <= frames_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      level_ff     <= level_in;
      timed_out_ff <= timed_out_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      cnt_ff       <= cnt_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      // Run set-up: clamp to the timeout and build numerator and divisor
      ticks_ext   = etsr_pkg::DUR_W'(req_payload.run_ticks);
      tmo_ext     = etsr_pkg::DUR_W'(timeout_ff);
      run_timeout = (ticks_ext >= tmo_ext);
      dur         = run_timeout ? tmo_ext : ticks_ext;
      period_eff  = (period_ff == '0) ? etsr_pkg::PERIOD_W'(1) : period_ff;

      // One restoring division step: shift in the next numerator bit, try subtract
      shifted = {rem_ff, quo_ff[etsr_pkg::NUM_W-1]};
      trial   = {1'b0, shifted} - {2'b00, div_ff};

      // Bit count for this run; the first run loses the start bit
      if (first_run_ff) begin
         n_eff = (quo_ff == '0) ? '0 : quo_ff - etsr_pkg::NUM_W'(1);
      end else begin
         n_eff = quo_ff;
      end
      // Saturate: anything past fifteen is an overrun either way
      n_sat = (n_eff > etsr_pkg::NUM_W'(15)) ? '1 : n_eff[etsr_pkg::NSAT_W-1:0];
      total_raw = etsr_pkg::TOT_W'(bit_count_ff) + etsr_pkg::TOT_W'(n_sat);

      // Fill the frame bits covered by this run with its level
      bits_new = frame_bits_ff;
      for (int i = 0; i < etsr_pkg::FRAME_BITS; i++) begin
         if (etsr_pkg::TOT_W'(i) >= etsr_pkg::TOT_W'(bit_count_ff)
             && etsr_pkg::TOT_W'(i) < total_raw) begin
            bits_new[i] = level_ff;
         end
      end

      // A low stop bit rounding up to nine is still a full frame
      if (total_raw == etsr_pkg::TOT_W'(etsr_pkg::FRAME_BITS + 1) && !level_ff) begin
         total = etsr_pkg::TOT_W'(etsr_pkg::FRAME_BITS);
      end else begin
         total = total_raw;
      end
      frame_done = timed_out_ff || (total >= etsr_pkg::TOT_W'(etsr_pkg::FRAME_BITS));
      emit       = frame_done && (total == etsr_pkg::TOT_W'(etsr_pkg::FRAME_BITS));

      value_new = bits_new[etsr_pkg::FRAME_BITS-1:1];
      serr      = (value_new != prev_ff + etsr_pkg::VALUE_W'(1));

      // Defaults: hold everything, drain the output register when taken
      state_in      = state_ff;
      in_frame_in   = in_frame_ff;
      first_run_in  = first_run_ff;
      bit_count_in  = bit_count_ff;
      frame_bits_in = frame_bits_ff;
      prev_in       = prev_ff;
      errors_in     = errors_ff;
      frames_in     = frames_ff;
      level_in      = level_ff;
      timed_out_in  = timed_out_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      cnt_in        = cnt_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      load_rsp      = 1'b0;

      case (state_ff)
         etsr_pkg::ST_IDLE: begin
            // High runs outside a frame are dropped here
            if (req_take && (in_frame_ff || !req_payload.run_level)) begin
               if (!in_frame_ff) begin
                  in_frame_in   = 1'b1;
                  first_run_in  = 1'b1;
                  bit_count_in  = '0;
                  frame_bits_in = '0;
               end
               level_in     = req_payload.run_level;
               timed_out_in = run_timeout;
               quo_in       = etsr_pkg::NUM_W'({dur, 1'b0}) + etsr_pkg::NUM_W'(period_eff);
               rem_in       = '0;
               div_in       = {period_eff, 1'b0};
               cnt_in       = etsr_pkg::CNT_W'(etsr_pkg::NUM_W);
               state_in     = etsr_pkg::ST_DIVIDE;
            end
         end

         etsr_pkg::ST_DIVIDE: begin
            if (!trial[etsr_pkg::DIV_W+1]) begin
               rem_in = trial[etsr_pkg::DIV_W-1:0];
               quo_in = {quo_ff[etsr_pkg::NUM_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[etsr_pkg::DIV_W-1:0];
               quo_in = {quo_ff[etsr_pkg::NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - etsr_pkg::CNT_W'(1);
            if (cnt_ff == etsr_pkg::CNT_W'(1)) begin
               state_in = etsr_pkg::ST_APPLY;
            end
         end

         etsr_pkg::ST_APPLY: begin
            // Hold while an earlier response still occupies the output register
            if (!(emit && rsp_valid_ff && rsp_stall)) begin
               frame_bits_in = bits_new;
               first_run_in  = 1'b0;
               state_in      = etsr_pkg::ST_IDLE;
               if (!frame_done) begin
                  bit_count_in = total[etsr_pkg::BITS_W-1:0];
               end else begin
                  in_frame_in  = 1'b0;
                  first_run_in = 1'b1;
                  bit_count_in = '0;
                  if (emit) begin
                     load_rsp                = 1'b1;
                     prev_in                 = value_new;
                     errors_in               = errors_ff + etsr_pkg::COUNT_W'(serr);
                     frames_in               = frames_ff + etsr_pkg::COUNT_W'(1);
                     rsp_in.value            = value_new;
                     rsp_in.sequence_error   = serr;
                     rsp_in.error_count      = errors_in;
                     rsp_in.frame_count      = frames_in;
                     rsp_valid_in            = 1'b1;
                  end
               end
            end
         end

         default: begin
            state_in = etsr_pkg::ST_IDLE;
         end
      endcase
   end

   // A response only appears straight after a run is applied
   a_rsp_after_apply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == etsr_pkg::ST_APPLY))
      else $error("response raised outside the apply step");

   // Outside a frame the bit position and start-bit flag are back at their opening values
   a_idle_frame_state: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (bit_count_ff == '0) && first_run_ff)
      else $error("frame state not cleared between frames");

   // Each loaded response advances the frame counter by exactly one
   a_frame_count_step: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (rsp_ff.frame_count == $past(frames_ff) + etsr_pkg::COUNT_W'(1)))
      else $error("frame counter did not advance by one");

   // No new request is taken while the divider is busy
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == etsr_pkg::ST_DIVIDE) |=> (state_ff != etsr_pkg::ST_IDLE)
         || $past(cnt_ff == etsr_pkg::CNT_W'(1)) || $past(state_ff != etsr_pkg::ST_DIVIDE))
      else $error("divider left before its last step");

endmodule
